// ===== sv/bqc_pkg.sv =====
// ----------------------------------------------------------------------------
// bqc_pkg
// Shared types and fixed formats of the biquad cascade: item actions,
// coefficient selects, accumulator operations and the state word format.
// ----------------------------------------------------------------------------
`default_nettype none

package bqc_pkg;

    // state words are Q9.39, the accumulator keeps two guard bits
    localparam int ST_BITS   = 48;
    localparam int ST_FRAC   = 39;
    localparam int ACC_BITS  = 50;
    localparam int NUM_COEFS = 5;

    typedef enum logic [1:0] {
        ACT_FILTER = 2'd0,
        ACT_COEF   = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        CF_B0 = 3'd0,
        CF_B1 = 3'd1,
        CF_B2 = 3'd2,
        CF_A1 = 3'd3,
        CF_A2 = 3'd4
    } t_coef_sel;

    typedef enum logic [1:0] {
        ACC_HOLD   = 2'd0,
        ACC_LOAD_W = 2'd1,
        ACC_SUB    = 2'd2,
        ACC_LOAD   = 2'd3
    } t_acc_op;

    typedef struct packed {
        logic    use_y;
        t_acc_op acc_op;
    } t_mac_ctl;

endpackage

`default_nettype wire

// ===== sv/bqc_coef_mem.sv =====
// ----------------------------------------------------------------------------
// bqc_coef_mem
// Coefficient store, five words per stage, one write and one registered read
// per cycle. Words never written read as the identity section.
// ----------------------------------------------------------------------------
`default_nettype none

module bqc_coef_mem #(
    parameter int MAX_STAGES = 8,
    parameter int COEF_BITS  = 32,
    localparam int SIW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_we,
    input  wire [SIW-1:0]                i_wstage,
    input  bqc_pkg::t_coef_sel           i_wsel,
    input  wire signed [COEF_BITS-1:0]   i_wdata,
    input  wire [SIW-1:0]                i_rstage,
    input  bqc_pkg::t_coef_sel           i_rsel,
    output logic signed [COEF_BITS-1:0]  o_rdata
);
    import bqc_pkg::*;

    localparam int DEPTH = MAX_STAGES * NUM_COEFS;
    localparam int CAW   = $clog2(DEPTH);
    localparam logic signed [COEF_BITS-1:0] CF_ONE = COEF_BITS'(1) << (COEF_BITS - 4);

    logic signed [COEF_BITS-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]            r_vld;
    logic signed [COEF_BITS-1:0] r_rdata;
    logic                        r_vld_q;
    logic                        r_b0_q;
    logic [CAW-1:0]              waddr;
    logic [CAW-1:0]              raddr;

    assign waddr = CAW'(int'(i_wstage) * NUM_COEFS + int'(i_wsel));
    assign raddr = CAW'(int'(i_rstage) * NUM_COEFS + int'(i_rsel));

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[waddr] <= i_wdata;
        end
        r_rdata <= r_mem[raddr];
        r_b0_q  <= (i_rsel == CF_B0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_vld_q <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[waddr] <= 1'b1;
            end
            r_vld_q <= r_vld[raddr];
        end
    end

    always_comb begin
        if (r_vld_q) begin
            o_rdata = r_rdata;
        end else if (r_b0_q) begin
            o_rdata = CF_ONE;
        end else begin
            o_rdata = '0;
        end
    end

endmodule

`default_nettype wire

// ===== sv/bqc_state_mem.sv =====
// ----------------------------------------------------------------------------
// bqc_state_mem
// Filter state store, one row of two state words per stage and channel.
// Row valid bits give the zero reset and a clear that empties every row at once.
// ----------------------------------------------------------------------------
`default_nettype none

module bqc_state_mem #(
    parameter int NROWS = 16,
    localparam int RAW = (NROWS > 1) ? $clog2(NROWS) : 1
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_clr,
    input  wire                                  i_we,
    input  wire [RAW-1:0]                        i_wrow,
    input  wire signed [bqc_pkg::ST_BITS-1:0]    i_wdata0,
    input  wire signed [bqc_pkg::ST_BITS-1:0]    i_wdata1,
    input  wire                                  i_re,
    input  wire [RAW-1:0]                        i_rrow,
    output logic signed [bqc_pkg::ST_BITS-1:0]   o_w0,
    output logic signed [bqc_pkg::ST_BITS-1:0]   o_w1
);
    import bqc_pkg::*;

    logic [2*ST_BITS-1:0] r_mem [NROWS];
    logic [NROWS-1:0]     r_vld;
    logic [2*ST_BITS-1:0] r_rdata;
    logic                 r_vld_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wrow] <= {i_wdata1, i_wdata0};
        end
        if (i_re) begin
            r_rdata <= r_mem[i_rrow];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_vld_q <= 1'b0;
        end else begin
            if (i_clr) begin
                r_vld <= '0;
            end else if (i_we) begin
                r_vld[i_wrow] <= 1'b1;
            end
            if (i_re) begin
                r_vld_q <= r_vld[i_rrow];
            end
        end
    end

    // rows not written since reset or clear read as zero
    assign o_w0 = r_vld_q ? r_rdata[ST_BITS-1:0]         : '0;
    assign o_w1 = r_vld_q ? r_rdata[2*ST_BITS-1:ST_BITS] : '0;

endmodule

`default_nettype wire

// ===== sv/bqc_mac.sv =====
// ----------------------------------------------------------------------------
// bqc_mac
// Shared multiply-accumulate unit: one registered coefficient-by-sample
// product, rounding into the state format, accumulate, saturation and the
// rounding of a stage output back to the sample format.
// ----------------------------------------------------------------------------
`default_nettype none

module bqc_mac #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 32
) (
    input  wire                                  i_clk,
    input  wire signed [COEF_BITS-1:0]           i_coef,
    input  wire signed [SAMPLE_BITS-1:0]         i_x,
    input  wire signed [SAMPLE_BITS-1:0]         i_y,
    input  wire signed [bqc_pkg::ST_BITS-1:0]    i_w,
    input  bqc_pkg::t_mac_ctl                    i_ctl,
    output logic signed [bqc_pkg::ST_BITS-1:0]   o_state,
    output logic signed [SAMPLE_BITS-1:0]        o_y
);
    import bqc_pkg::*;

    localparam int PW      = SAMPLE_BITS + COEF_BITS;
    localparam int PSH     = (SAMPLE_BITS - 1) + (COEF_BITS - 4) - ST_FRAC;
    localparam int SH_R    = (PSH > 0) ? PSH : 0;
    localparam int SH_L    = (PSH < 0) ? -PSH : 0;
    localparam int HALF_SH = (SH_R > 0) ? SH_R - 1 : 0;
    localparam int RW      = PW + SH_L + 1;
    localparam logic [RW-1:0] HALF = (SH_R > 0) ? (RW'(1) << HALF_SH) : RW'(0);
    localparam int YSH     = ST_FRAC - (SAMPLE_BITS - 1);
    localparam int TW      = ST_BITS + 1;
    localparam logic [TW-1:0] YHALF = TW'(1) << (YSH - 1);

    localparam logic signed [ACC_BITS-1:0] ST_MAX =
        {{(ACC_BITS-ST_BITS+1){1'b0}}, {(ST_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ST_MIN =
        {{(ACC_BITS-ST_BITS+1){1'b1}}, {(ST_BITS-1){1'b0}}};
    localparam logic signed [TW-1:0] SMP_MAX =
        {{(TW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [TW-1:0] SMP_MIN =
        {{(TW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [PW-1:0]       r_prod;
    logic signed [ACC_BITS-1:0] r_acc;
    logic signed [SAMPLE_BITS-1:0] opnd;
    logic signed [RW-1:0]       pext;
    logic signed [RW-1:0]       rsum;
    logic signed [RW-1:0]       rshift;
    logic signed [ACC_BITS-1:0] rnd;
    logic signed [ACC_BITS-1:0] n_acc;
    logic signed [TW-1:0]       ysum;
    logic signed [TW-1:0]       yq;
    logic                       rcorr;

    assign opnd = i_ctl.use_y ? i_y : i_x;

    always_ff @(posedge i_clk) begin
        r_prod <= i_coef * opnd;
        r_acc  <= n_acc;
    end

    // round the magnitude to nearest, ties away from zero
    assign rcorr  = r_prod[PW-1] && (SH_R > 0);
    assign pext   = RW'(r_prod) <<< SH_L;
    assign rsum   = pext + HALF - {{(RW-1){1'b0}}, rcorr};
    assign rshift = rsum >>> SH_R;
    assign rnd    = ACC_BITS'(rshift);

    always_comb begin
        unique case (i_ctl.acc_op)
            ACC_HOLD:   n_acc = r_acc;
            ACC_LOAD_W: n_acc = ACC_BITS'(i_w) + rnd;
            ACC_SUB:    n_acc = r_acc - rnd;
            ACC_LOAD:   n_acc = rnd;
            default:    n_acc = r_acc;
        endcase
    end

    always_comb begin
        if (r_acc > ST_MAX) begin
            o_state = ST_BITS'(ST_MAX);
        end else if (r_acc < ST_MIN) begin
            o_state = ST_BITS'(ST_MIN);
        end else begin
            o_state = ST_BITS'(r_acc);
        end
    end

    // state to sample format: round half up, then saturate
    assign ysum = TW'(o_state) + YHALF;
    assign yq   = ysum >>> YSH;

    always_comb begin
        if (yq > SMP_MAX) begin
            o_y = SAMPLE_BITS'(SMP_MAX);
        end else if (yq < SMP_MIN) begin
            o_y = SAMPLE_BITS'(SMP_MIN);
        end else begin
            o_y = SAMPLE_BITS'(yq);
        end
    end

endmodule

`default_nettype wire

// ===== sv/biquad_cascade_tdf2_unit.sv =====
// ----------------------------------------------------------------------------
// biquad_cascade_tdf2_unit
// Multichannel cascade of transposed direct form II biquads on one shared
// multiply-accumulate unit, stepped by a phase sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one word per item: a
//   sample to filter, a coefficient write or a state clear. Output channel
//   (o_out_valid / i_out_stall) returns one word per sample item.
//   A filtered sample runs phases PH0 to PH6 per active stage on the shared
//   multiplier (five products per stage and two idle phases, one of them
//   waiting for the stage output); S_TAIL0 and S_TAIL1 then finish and write
//   back the last stage and S_EMIT presents the result. A pass-through sample
//   goes straight to S_EMIT. Coefficient writes and clears return nothing and
//   leave the unit idle. The input stalls while a sample is in work. A stalled
//   output holds its word; the next result waits in the sequencer until the
//   word is taken. Reset sets every section to identity, zeroes all filter
//   state, sets stage_count to 0 and active_channels to 2. Registers are
//   written over the APB port at byte address 0 and 4; the user must write
//   them only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_cascade_tdf2_unit #(
    parameter int MAX_STAGES   = 8,
    parameter int MAX_CHANNELS = 2,
    parameter int SAMPLE_BITS  = 24,
    parameter int COEF_BITS    = 32
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // sample / command channel
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  wire [1:0]                     i_action,
    input  wire                           i_channel,
    input  wire signed [SAMPLE_BITS-1:0]  i_sample_in,
    input  wire [2:0]                     i_stage_index,
    input  wire [2:0]                     i_coef_index,
    input  wire signed [31:0]             i_coef_value,
    // result channel
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output logic                          o_out_channel,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    // configuration
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire [2:0]                     paddr,
    input  wire [31:0]                    pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import bqc_pkg::*;

    localparam int SIW   = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int NROWS = MAX_STAGES * MAX_CHANNELS;
    localparam int RAW   = (NROWS > 1) ? $clog2(NROWS) : 1;

    localparam logic REG_STAGE_COUNT = 1'b0;
    localparam logic REG_ACTIVE_CH   = 1'b1;

    localparam logic [2:0] PH0 = 3'd0;
    localparam logic [2:0] PH1 = 3'd1;
    localparam logic [2:0] PH2 = 3'd2;
    localparam logic [2:0] PH3 = 3'd3;
    localparam logic [2:0] PH4 = 3'd4;
    localparam logic [2:0] PH5 = 3'd5;
    localparam logic [2:0] PH6 = 3'd6;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RUN   = 5'b00010,
        S_TAIL0 = 5'b00100,
        S_TAIL1 = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state                  r_state;
    logic [3:0]              r_stage_count;
    logic [1:0]              r_active_ch;
    logic [2:0]              r_ph;
    logic [SIW-1:0]          r_stg;
    logic [SIW-1:0]          r_last;
    logic                    r_prev;
    logic                    r_ch;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [SAMPLE_BITS-1:0] r_y;
    logic signed [ST_BITS-1:0]     r_n1;
    logic [RAW-1:0]          r_wb_row;
    logic                    r_o_valid;
    logic                    r_o_ch;
    logic signed [SAMPLE_BITS-1:0] r_o_sample;

    t_action                 act;
    logic                    in_acc;
    logic                    cfg_we;
    logic [3:0]              eff_stages;
    logic [SIW-1:0]          last_stg;
    logic                    filt;
    logic                    cf_we;
    logic [SIW-1:0]          cf_wstage;
    logic signed [COEF_BITS-1:0] cf_wdata;
    t_coef_sel               cf_rsel;
    logic signed [COEF_BITS-1:0] cf_rdata;
    logic                    st_clr;
    logic                    st_we;
    logic                    st_re;
    logic [RAW-1:0]          cur_row;
    logic signed [ST_BITS-1:0] st_w0;
    logic signed [ST_BITS-1:0] st_w1;
    logic signed [ST_BITS-1:0] mac_w;
    t_mac_ctl                mac_ctl;
    logic signed [ST_BITS-1:0] mac_state;
    logic signed [SAMPLE_BITS-1:0] mac_y;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_count <= 4'd0;
            r_active_ch   <= 2'd2;
        end else if (cfg_we) begin
            unique case (paddr[2])
                REG_STAGE_COUNT: r_stage_count <= pwdata[3:0];
                REG_ACTIVE_CH:   r_active_ch   <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_STAGE_COUNT: prdata = {28'd0, r_stage_count};
            REG_ACTIVE_CH:   prdata = {30'd0, r_active_ch};
            default:         prdata = '0;
        endcase
    end

    // ---------------- item decode ----------------
    assign act        = t_action'(i_action);
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);

    assign eff_stages = (r_stage_count > MAX_STAGES) ? 4'(MAX_STAGES) : r_stage_count;
    assign last_stg   = SIW'(eff_stages - 4'd1);
    assign filt       = (eff_stages != 4'd0) && ({1'b0, i_channel} < r_active_ch)
                        && (32'(i_channel) < MAX_CHANNELS);

    // drop writes to a stage or coefficient that does not exist
    assign cf_we     = in_acc && (act == ACT_COEF) && (32'(i_stage_index) < MAX_STAGES)
                       && (i_coef_index <= CF_A2);
    assign cf_wstage = SIW'(i_stage_index);
    assign cf_wdata  = COEF_BITS'(i_coef_value);
    assign st_clr    = in_acc && (act == ACT_CLEAR);

    assign cur_row = RAW'(int'(r_stg) * MAX_CHANNELS + int'(r_ch));

    // ---------------- phase sequencer ----------------
    // Per stage: b0*x, b1*x, a1*y, b2*x, a2*y. The last subtract and the
    // write-back of a stage overlap the first two phases of the next.
    always_comb begin
        cf_rsel = CF_B0;
        st_re   = 1'b0;
        st_we   = 1'b0;
        mac_ctl = '{use_y: 1'b0, acc_op: ACC_HOLD};
        unique case (r_state)
            S_RUN: begin
                case (r_ph)
                    PH0: begin
                        cf_rsel = CF_B0;
                        st_re   = 1'b1;
                        if (r_prev) begin
                            mac_ctl.acc_op = ACC_SUB;
                        end
                    end
                    PH1: begin
                        cf_rsel = CF_B1;
                        st_we   = r_prev;
                    end
                    PH2: begin
                        cf_rsel        = CF_A1;
                        mac_ctl.acc_op = ACC_LOAD_W;
                    end
                    PH3: begin
                        cf_rsel        = CF_A1;
                        mac_ctl.acc_op = ACC_LOAD_W;
                    end
                    PH4: begin
                        cf_rsel       = CF_B2;
                        mac_ctl.use_y = 1'b1;
                    end
                    PH5: begin
                        cf_rsel        = CF_A2;
                        mac_ctl.acc_op = ACC_SUB;
                    end
                    PH6: begin
                        cf_rsel        = CF_A2;
                        mac_ctl.use_y  = 1'b1;
                        mac_ctl.acc_op = ACC_LOAD;
                    end
                    default: ;
                endcase
            end
            S_TAIL0: mac_ctl.acc_op = ACC_SUB;
            S_TAIL1: st_we = 1'b1;
            default: ;
        endcase
    end

    assign mac_w = (r_ph == PH2) ? st_w0 : st_w1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && !i_out_stall && (r_state != S_EMIT)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && (act == ACT_FILTER)) begin
                        r_ch    <= i_channel;
                        r_x     <= i_sample_in;
                        r_y     <= i_sample_in;
                        r_stg   <= '0;
                        r_ph    <= PH0;
                        r_prev  <= 1'b0;
                        r_last  <= last_stg;
                        r_state <= filt ? S_RUN : S_EMIT;
                    end
                end
                S_RUN: begin
                    if ((r_ph == PH0) && r_prev) begin
                        r_x <= r_y;
                    end
                    if (r_ph == PH3) begin
                        r_y <= mac_y;
                    end
                    if (r_ph == PH6) begin
                        r_n1     <= mac_state;
                        r_wb_row <= cur_row;
                        if (r_stg == r_last) begin
                            r_state <= S_TAIL0;
                        end else begin
                            r_stg  <= r_stg + SIW'(1);
                            r_ph   <= PH0;
                            r_prev <= 1'b1;
                        end
                    end else begin
                        r_ph <= r_ph + 3'd1;
                    end
                end
                S_TAIL0: r_state <= S_TAIL1;
                S_TAIL1: r_state <= S_EMIT;
                S_EMIT: begin
                    // hold until the output register is free
                    if (!r_o_valid || !i_out_stall) begin
                        r_o_valid  <= 1'b1;
                        r_o_ch     <= r_ch;
                        r_o_sample <= r_y;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_out_channel = r_o_ch;
    assign o_sample_out  = r_o_sample;

    // ---------------- datapath ----------------
    bqc_coef_mem #(
        .MAX_STAGES (MAX_STAGES),
        .COEF_BITS  (COEF_BITS)
    ) u_coef_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (cf_we),
        .i_wstage (cf_wstage),
        .i_wsel   (t_coef_sel'(i_coef_index)),
        .i_wdata  (cf_wdata),
        .i_rstage (r_stg),
        .i_rsel   (cf_rsel),
        .o_rdata  (cf_rdata)
    );

    bqc_state_mem #(
        .NROWS (NROWS)
    ) u_state_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clr    (st_clr),
        .i_we     (st_we),
        .i_wrow   (r_wb_row),
        .i_wdata0 (r_n1),
        .i_wdata1 (mac_state),
        .i_re     (st_re),
        .i_rrow   (cur_row),
        .o_w0     (st_w0),
        .o_w1     (st_w1)
    );

    bqc_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_coef  (cf_rdata),
        .i_x     (r_x),
        .i_y     (r_y),
        .i_w     (mac_w),
        .i_ctl   (mac_ctl),
        .o_state (mac_state),
        .o_y     (mac_y)
    );

endmodule

`default_nettype wire
